// ===== design/cdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdm_pkg: shared codes and types of the CD-ROM motion controller
// Function codes, motion codes, drive error codes, register indexes, flags.
// ----------------------------------------------------------------------------
package cdm_pkg;

	// function codes of a request
	localparam logic [2:0] FN_TICK     = 3'd0;
	localparam logic [2:0] FN_SPIN     = 3'd1;
	localparam logic [2:0] FN_SEEK     = 3'd2;
	localparam logic [2:0] FN_STOP     = 3'd3;
	localparam logic [2:0] FN_MEDIUM   = 3'd4;
	localparam logic [2:0] FN_RESET    = 3'd5;

	// motion codes
	localparam logic [2:0] MO_STOPPED   = 3'd0;
	localparam logic [2:0] MO_SPIN_UP   = 3'd1;
	localparam logic [2:0] MO_READY     = 3'd2;
	localparam logic [2:0] MO_SEEKING   = 3'd3;
	localparam logic [2:0] MO_READING   = 3'd4;
	localparam logic [2:0] MO_HOLD      = 3'd5;
	localparam logic [2:0] MO_SPIN_DOWN = 3'd6;

	// drive error codes
	localparam logic [2:0] ER_NONE    = 3'd0;
	localparam logic [2:0] ER_RESET   = 3'd1;
	localparam logic [2:0] ER_SPINUP  = 3'd2;
	localparam logic [2:0] ER_UNIT    = 3'd3;
	localparam logic [2:0] ER_FOCUS   = 3'd4;
	localparam logic [2:0] ER_ADDRESS = 3'd5;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SPIN_UP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEEK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIAG    = 2'd2;

	// register reset values
	localparam int unsigned SPIN_UP_TICKS_RST = 2000000;
	localparam int unsigned SEEK_TICKS_RST    = 40000;
	localparam int unsigned DIAG_TICKS_RST    = 10000;

	// lead-in offset added to a sector for the status address
	localparam int unsigned LEAD_IN = 150;

	typedef struct packed {
		logic sterr;     // focus or address error raised
		logic attn;      // attention line
		logic notice;    // spin request awaiting arrival
		logic invalid;   // seek was clamped
		logic seekread;  // read on arrival
		logic pending;   // seek pending
		logic known;     // medium seen at least once
		logic present;   // disc inserted
	} flags_t;

endpackage

// ===== design/cdm_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdm_cfg: timer configuration registers
// Three tick counts, written by index; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module cdm_cfg
	import cdm_pkg::*;
#(
	parameter int TIMER_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [TIMER_BITS-1:0] wr_data,
	output logic [TIMER_BITS-1:0] spin_up_ticks,
	output logic [TIMER_BITS-1:0] seek_ticks,
	output logic [TIMER_BITS-1:0] diag_ticks
);

	logic [TIMER_BITS-1:0] spin_up_q, seek_q, diag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_up_q <= TIMER_BITS'(SPIN_UP_TICKS_RST);
			seek_q    <= TIMER_BITS'(SEEK_TICKS_RST);
			diag_q    <= TIMER_BITS'(DIAG_TICKS_RST);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SPIN_UP: spin_up_q <= wr_data;
				REG_SEEK:    seek_q    <= wr_data;
				REG_DIAG:    diag_q    <= wr_data;
				default:     ;
			endcase
		end
	end

	assign spin_up_ticks = spin_up_q;
	assign seek_ticks    = seek_q;
	assign diag_ticks    = diag_q;

endmodule

// ===== design/cdm_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdm_core: motion state and its next-state update
// Holds drive state; applies one request per enabled cycle and shows the
// state after it on the next-state outputs.
// ----------------------------------------------------------------------------
module cdm_core
	import cdm_pkg::*;
#(
	parameter int SECTOR_BITS = 19,
	parameter int TIMER_BITS  = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [2:0]             func,
	input  logic [SECTOR_BITS-1:0] target_sector,
	input  logic                   read_after_seek,
	input  logic                   medium_present,
	input  logic [SECTOR_BITS-1:0] medium_size,
	input  logic [TIMER_BITS-1:0]  spin_up_ticks,
	input  logic [TIMER_BITS-1:0]  seek_ticks,
	input  logic [TIMER_BITS-1:0]  diag_ticks,
	output logic [2:0]             n_motion,
	output logic [SECTOR_BITS-1:0] n_head,
	output logic [2:0]             n_first_err,
	output logic [SECTOR_BITS:0]   n_err_addr,
	output flags_t                 n_flags
);

	localparam logic [TIMER_BITS-1:0] T_ONE = TIMER_BITS'(1);

	logic [2:0]             motion_q;
	logic [TIMER_BITS-1:0]  mcnt_q, dcnt_q;
	logic [SECTOR_BITS-1:0] head_q, goal_q, size_q;
	flags_t                 flags_q;
	logic [2:0]             first_err_q;
	logic [SECTOR_BITS:0]   err_addr_q;

	logic [TIMER_BITS-1:0]  n_mcnt, n_dcnt;
	logic [SECTOR_BITS-1:0] n_goal, n_size;
	logic                   raise_a, raise_b;
	logic [2:0]             code_a, code_b;
	logic                   bad, changed;
	logic [TIMER_BITS-1:0]  spin_dur, seek_dur, diag_dur;
	logic [SECTOR_BITS-1:0] nsize;

	// zero duration runs as one tick
	assign spin_dur = (spin_up_ticks == '0) ? T_ONE : spin_up_ticks;
	assign seek_dur = (seek_ticks == '0) ? T_ONE : seek_ticks;
	assign diag_dur = (diag_ticks == '0) ? T_ONE : diag_ticks;

	always_comb begin
		n_motion    = motion_q;
		n_mcnt      = mcnt_q;
		n_dcnt      = dcnt_q;
		n_head      = head_q;
		n_goal      = goal_q;
		n_size      = size_q;
		n_flags     = flags_q;
		n_first_err = first_err_q;
		n_err_addr  = err_addr_q;
		raise_a     = 1'b0;
		raise_b     = 1'b0;
		code_a      = ER_NONE;
		code_b      = ER_NONE;
		bad         = 1'b0;
		changed     = 1'b0;
		nsize       = medium_present ? medium_size : '0;

		unique case (func)
			FN_TICK: begin
				// diagnostic countdown served first
				if (dcnt_q != '0) begin
					n_dcnt = dcnt_q - T_ONE;
					if (n_dcnt == '0) begin
						raise_a = 1'b1;
						code_a  = ER_RESET;
					end
				end
				if (mcnt_q != '0) begin
					n_mcnt = mcnt_q - T_ONE;
					if (n_mcnt == '0) begin
						if (motion_q == MO_SPIN_UP) begin
							n_motion = MO_READY;
							if (flags_q.pending) begin
								n_motion = MO_SEEKING;
								n_mcnt   = seek_dur;
							end
						end else if (motion_q == MO_SEEKING) begin
							n_head          = goal_q;
							n_motion        = flags_q.seekread ? MO_READING : MO_HOLD;
							n_flags.pending = 1'b0;
							if (flags_q.invalid) begin
								raise_b = 1'b1;
								code_b  = ER_ADDRESS;
							end else if (flags_q.notice) begin
								raise_b = 1'b1;
								code_b  = ER_SPINUP;
							end
							n_flags.invalid = 1'b0;
							n_flags.notice  = 1'b0;
						end else if (motion_q == MO_SPIN_DOWN) begin
							n_motion = MO_STOPPED;
						end
					end
				end
			end
			FN_SPIN, FN_SEEK: begin
				if (!flags_q.present) begin
					raise_b = 1'b1;
					code_b  = ER_FOCUS;
				end else begin
					if (func == FN_SPIN) begin
						n_flags.notice   = 1'b1;
						n_flags.seekread = 1'b0;
						n_flags.invalid  = 1'b0;
						n_goal           = '0;
					end else begin
						if (motion_q == MO_READING)
							n_motion = MO_HOLD;
						bad = target_sector >= size_q;
						if (bad)
							n_goal = (size_q != '0) ? size_q - SECTOR_BITS'(1) : '0;
						else
							n_goal = target_sector;
						n_flags.notice   = 1'b0;
						n_flags.invalid  = bad;
						n_flags.seekread = !bad && read_after_seek;
					end
					n_flags.pending = 1'b1;
					// start motion
					if (n_motion == MO_STOPPED || n_motion == MO_SPIN_DOWN) begin
						n_motion = MO_SPIN_UP;
						n_mcnt   = spin_dur;
					end else if (n_motion != MO_SPIN_UP) begin
						n_motion = MO_SEEKING;
						n_mcnt   = seek_dur;
					end
				end
			end
			FN_STOP: begin
				if (motion_q == MO_READING)
					n_motion = MO_HOLD;
			end
			FN_MEDIUM: begin
				changed = flags_q.known &&
					(flags_q.present != medium_present || size_q != nsize);
				n_flags.known   = 1'b1;
				n_flags.present = medium_present;
				n_size          = nsize;
				if (motion_q == MO_READING)
					n_motion = MO_HOLD;
				if (!medium_present) begin
					n_motion        = MO_STOPPED;
					n_mcnt          = '0;
					n_flags.pending = 1'b0;
					n_flags.invalid = 1'b0;
				end
				if (changed) begin
					raise_b = 1'b1;
					code_b  = ER_UNIT;
				end
			end
			FN_RESET: begin
				n_motion    = MO_STOPPED;
				n_mcnt      = '0;
				n_dcnt      = diag_dur;
				n_head      = '0;
				n_goal      = '0;
				n_flags     = '0;
				n_flags.present = flags_q.present;
				n_flags.known   = flags_q.known;
				n_first_err = ER_NONE;
				n_err_addr  = '0;
			end
			default: ;
		endcase

		// error latching; the later raise sets the address
		if (raise_a) begin
			if (n_first_err == ER_NONE)
				n_first_err = code_a;
			n_err_addr   = {1'b0, head_q} + (SECTOR_BITS+1)'(LEAD_IN);
			n_flags.attn = 1'b1;
		end
		if (raise_b) begin
			if (n_first_err == ER_NONE)
				n_first_err = code_b;
			if (code_b == ER_FOCUS || code_b == ER_ADDRESS)
				n_flags.sterr = 1'b1;
			n_err_addr   = {1'b0, n_head} + (SECTOR_BITS+1)'(LEAD_IN);
			n_flags.attn = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motion_q    <= MO_STOPPED;
			mcnt_q      <= '0;
			dcnt_q      <= TIMER_BITS'(DIAG_TICKS_RST);
			head_q      <= '0;
			goal_q      <= '0;
			size_q      <= '0;
			flags_q     <= '0;
			first_err_q <= ER_NONE;
			err_addr_q  <= '0;
		end else if (en) begin
			motion_q    <= n_motion;
			mcnt_q      <= n_mcnt;
			dcnt_q      <= n_dcnt;
			head_q      <= n_head;
			goal_q      <= n_goal;
			size_q      <= n_size;
			flags_q     <= n_flags;
			first_err_q <= n_first_err;
			err_addr_q  <= n_err_addr;
		end
	end

endmodule

// ===== design/cdrom_motion_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrom_motion_controller: spindle, pickup and error status of a CD-ROM drive
// Takes tick and command requests and returns one status request for each.
// ----------------------------------------------------------------------------
// Use:
//   cmd channel (cmd_valid/cmd_stall): func plus seek and medium fields.
//   status channel (status_valid/status_stall): drive state after the request.
//   cfg channel (cfg_valid/cfg_ready, always ready): timer registers by
//   index; write only with the block idle.
// Path: request registered in the input stage; the state is then updated
// and the status registered in the status register.
// Throughput: one request per cycle unless status stalls; the state update is
// one pass of compares and two decrements between input and status registers.
// Reset: asynchronous; motion stopped, no disc, errors clear, diagnostic
// countdown loaded with the reset value of diag_ticks, timers at defaults.
// Stall: a held status freezes the input stage; the cmd side sees
// cmd_stall once that stage is full, so nothing is dropped.
// ----------------------------------------------------------------------------
module cdrom_motion_controller
	import cdm_pkg::*;
#(
	parameter int SECTOR_BITS = 19,
	parameter int TIMER_BITS  = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command requests
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  logic [2:0]             func,
	input  logic [SECTOR_BITS-1:0] target_sector,
	input  logic                   read_after_seek,
	input  logic                   medium_present,
	input  logic [SECTOR_BITS-1:0] medium_size,
	// status requests
	output logic                   status_valid,
	input  logic                   status_stall,
	output logic [2:0]             motion,
	output logic [SECTOR_BITS-1:0] current_sector,
	output logic [2:0]             err_code,
	output logic                   hard_err,
	output logic                   attention,
	output logic                   no_disc,
	output logic                   read_busy,
	output logic [SECTOR_BITS:0]   err_address,
	// configuration writes
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [TIMER_BITS-1:0]  cfg_data
);

	logic [TIMER_BITS-1:0] spin_up_ticks, seek_ticks, diag_ticks;

	// input stage
	logic                   valid_s1;
	logic [2:0]             func_s1;
	logic [SECTOR_BITS-1:0] target_s1, size_s1;
	logic                   rd_s1, present_s1;

	logic out_block, s1_go, cmd_take;

	// next state from the core
	logic [2:0]             n_motion, n_first_err;
	logic [SECTOR_BITS-1:0] n_head;
	logic [SECTOR_BITS:0]   n_err_addr;
	flags_t                 n_flags;

	// status register
	logic                   status_valid_q;
	logic [2:0]             motion_q, err_code_q;
	logic [SECTOR_BITS-1:0] sector_q;
	logic                   sterr_q, attn_q, door_q, data_q;
	logic [SECTOR_BITS:0]   addr_q;

	assign cfg_ready = 1'b1;

	cdm_cfg #(.TIMER_BITS(TIMER_BITS)) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (cfg_valid && cfg_ready),
		.wr_index      (cfg_index),
		.wr_data       (cfg_data),
		.spin_up_ticks (spin_up_ticks),
		.seek_ticks    (seek_ticks),
		.diag_ticks    (diag_ticks)
	);

	// status held while the receiver stalls; input stage waits behind it
	assign out_block = status_valid_q && status_stall;
	assign s1_go     = valid_s1 && !out_block;
	assign cmd_stall = valid_s1 && out_block;
	assign cmd_take  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			func_s1    <= func;
			target_s1  <= target_sector;
			rd_s1      <= read_after_seek;
			present_s1 <= medium_present;
			size_s1    <= medium_size;
		end
	end

	cdm_core #(.SECTOR_BITS(SECTOR_BITS), .TIMER_BITS(TIMER_BITS)) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (s1_go),
		.func            (func_s1),
		.target_sector   (target_s1),
		.read_after_seek (rd_s1),
		.medium_present  (present_s1),
		.medium_size     (size_s1),
		.spin_up_ticks   (spin_up_ticks),
		.seek_ticks      (seek_ticks),
		.diag_ticks      (diag_ticks),
		.n_motion        (n_motion),
		.n_head          (n_head),
		.n_first_err     (n_first_err),
		.n_err_addr      (n_err_addr),
		.n_flags         (n_flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (s1_go) begin
			status_valid_q <= 1'b1;
		end else if (!status_stall) begin
			status_valid_q <= 1'b0;
		end
	end

	// status payload: state after the request
	always_ff @(posedge clk) begin
		if (s1_go) begin
			motion_q   <= n_motion;
			sector_q   <= n_head;
			err_code_q <= n_first_err;
			sterr_q    <= n_flags.sterr;
			attn_q     <= n_flags.attn;
			door_q     <= !n_flags.present;
			data_q     <= (n_motion == MO_READING);
			addr_q     <= n_err_addr;
		end
	end

	assign status_valid   = status_valid_q;
	assign motion         = motion_q;
	assign current_sector = sector_q;
	assign err_code       = err_code_q;
	assign hard_err       = sterr_q;
	assign attention      = attn_q;
	assign no_disc        = door_q;
	assign read_busy      = data_q;
	assign err_address    = addr_q;

endmodule
